// ===== hw/rtl/sbm_pkg.sv =====
// sbm_pkg: word types, register indexes and fixed-point constants of the
// spectrum band meter. No dependencies; every module of the meter imports it.
package sbm_pkg;

  localparam int BAND_W     = 6;
  localparam int BIN_W      = 24;
  localparam int MAG_W      = 23;
  localparam int LVL_W      = 12;
  localparam int DB_W       = 8;
  localparam int HOLD_W     = 8;
  localparam int EXP_W      = 5;
  localparam int FRAC_W     = 5;
  localparam int LQ_W       = 13;
  localparam int ATT_W      = 16;
  localparam int PROD_W     = 24;
  localparam int SPAN_W     = 16;
  localparam int MUL_W      = 28;
  localparam int NUM_W      = 19;
  localparam int DEN_W      = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEVEL        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DB           = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BAR_FALL_STEP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PEAK_HOLD_FRAMES = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PEAK_FALL_STEP   = 3'd4;

  localparam logic [LVL_W-1:0]         RST_MAX_LEVEL        = 12'd255;
  localparam logic signed [DB_W-1:0]   RST_MIN_DB           = -8'sd70;
  localparam logic [LVL_W-1:0]         RST_BAR_FALL_STEP    = 12'd40;
  localparam logic [HOLD_W-1:0]        RST_PEAK_HOLD_FRAMES = 8'd40;
  localparam logic [LVL_W-1:0]         RST_PEAK_FALL_STEP   = 12'd10;

  // log2 of full scale in Q8, 20*log10(2) in Q8, rounding half
  localparam logic [LQ_W-1:0]   LOG_TOP_Q8  = 13'd5888;
  localparam logic [PROD_W-1:0] DB_PER_OCT  = 24'd1541;
  localparam logic [PROD_W-1:0] ROUND_Q8    = 24'd128;

  // round(256*log2(1+i/32))
  localparam logic [7:0] LOG2_FRAC [32] = '{
    8'd0,   8'd11,  8'd22,  8'd33,  8'd44,  8'd54,  8'd63,  8'd73,
    8'd82,  8'd92,  8'd100, 8'd109, 8'd118, 8'd126, 8'd134, 8'd142,
    8'd150, 8'd157, 8'd165, 8'd172, 8'd179, 8'd186, 8'd193, 8'd200,
    8'd207, 8'd213, 8'd220, 8'd226, 8'd232, 8'd238, 8'd244, 8'd250
  };

  typedef struct packed {
    logic [BAND_W-1:0]       band_index;
    logic signed [BIN_W-1:0] bin_value;
    logic                    band_last;
  } in_word_t;

  typedef struct packed {
    logic [BAND_W-1:0] out_band;
    logic [LVL_W-1:0]  bar_level;
    logic [LVL_W-1:0]  peak_level;
  } out_word_t;

  typedef struct packed {
    logic [LVL_W-1:0]       max_level;
    logic signed [DB_W-1:0] min_db;
    logic [LVL_W-1:0]       bar_fall_step;
    logic [HOLD_W-1:0]      peak_hold_frames;
    logic [LVL_W-1:0]       peak_fall_step;
  } cfg_t;

  typedef struct packed {
    logic              vld;
    logic [BAND_W-1:0] band;
    logic [MAG_W-1:0]  mag;
  } mag_tok_t;

  typedef struct packed {
    logic              vld;
    logic [BAND_W-1:0] band;
    logic [NUM_W-1:0]  num;
    logic [DEN_W-1:0]  den;
  } div_tok_t;

  typedef struct packed {
    logic              vld;
    logic [BAND_W-1:0] band;
    logic [LVL_W-1:0]  level;
  } lvl_tok_t;

endpackage

// ===== hw/rtl/sbm_level.sv =====
// sbm_level: band maximum to scaled level numerator, five stages (msb search,
// log2 lookup, dB multiply, clamp, full-scale multiply). Depends on sbm_pkg.
module sbm_level (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  sbm_pkg::cfg_t     cfg,
  input  sbm_pkg::mag_tok_t in_tok,
  output sbm_pkg::div_tok_t out_tok
);
  import sbm_pkg::*;

  logic [EXP_W-1:0]  msb_pos;
  logic              a_vld_r;
  logic [BAND_W-1:0] a_band_r;
  logic [MAG_W-1:0]  a_mag_r;
  logic [EXP_W-1:0]  a_exp_r;
  logic              a_zero_r;

  logic [MAG_W-1:0]  norm;
  logic [FRAC_W-1:0] frac_idx;
  logic              b_vld_r;
  logic [BAND_W-1:0] b_band_r;
  logic              b_zero_r;
  logic [LQ_W-1:0]   b_lq8_r;

  logic [LQ_W-1:0]   att_base;
  logic [PROD_W-1:0] att_prod;
  logic              c_vld_r;
  logic [BAND_W-1:0] c_band_r;
  logic              c_zero_r;
  logic [ATT_W-1:0]  c_att_r;

  logic [DEN_W-1:0]  db_span;
  logic [SPAN_W-1:0] span;
  logic [ATT_W-1:0]  att_clamp;
  logic              d_vld_r;
  logic [BAND_W-1:0] d_band_r;
  logic [DEN_W-1:0]  d_den_r;
  logic [SPAN_W-1:0] d_diff_r;

  logic [MUL_W-1:0]  scaled;
  div_tok_t          e_tok_r;

  always_comb begin
    msb_pos = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (in_tok.mag[i]) begin
        msb_pos = EXP_W'(i);
      end
    end
  end

  assign norm     = a_mag_r << (EXP_W'(MAG_W - 1) - a_exp_r);
  assign frac_idx = norm[MAG_W-2 -: FRAC_W];

  assign att_base = LOG_TOP_Q8 - b_lq8_r;
  assign att_prod = PROD_W'(att_base) * DB_PER_OCT + ROUND_Q8;

  always_comb begin
    if (!cfg.min_db[DB_W-1]) begin
      db_span = DEN_W'(1);
    end else begin
      db_span = DEN_W'(~cfg.min_db) + DEN_W'(1);
    end
    span      = {db_span, 8'b0};
    att_clamp = (c_att_r > span) ? span : c_att_r;
  end

  assign scaled = MUL_W'(cfg.max_level) * MUL_W'(d_diff_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r     <= 1'b0;
      b_vld_r     <= 1'b0;
      c_vld_r     <= 1'b0;
      d_vld_r     <= 1'b0;
      e_tok_r.vld <= 1'b0;
    end else if (en) begin
      a_vld_r  <= in_tok.vld;
      a_band_r <= in_tok.band;
      a_mag_r  <= in_tok.mag;
      a_exp_r  <= msb_pos;
      a_zero_r <= (in_tok.mag == '0);

      b_vld_r  <= a_vld_r;
      b_band_r <= a_band_r;
      b_zero_r <= a_zero_r;
      b_lq8_r  <= {a_exp_r, 8'b0} + LQ_W'(LOG2_FRAC[frac_idx]);

      c_vld_r  <= b_vld_r;
      c_band_r <= b_band_r;
      c_zero_r <= b_zero_r;
      c_att_r  <= att_prod[PROD_W-1:8];

      d_vld_r  <= c_vld_r;
      d_band_r <= c_band_r;
      d_den_r  <= db_span;
      d_diff_r <= c_zero_r ? '0 : (span - att_clamp);

      e_tok_r.vld  <= d_vld_r;
      e_tok_r.band <= d_band_r;
      e_tok_r.num  <= scaled[NUM_W+7:8];
      e_tok_r.den  <= d_den_r;
    end
  end

  assign out_tok = e_tok_r;

endmodule

// ===== hw/rtl/sbm_div.sv =====
// sbm_div: pipelined restoring divider, one quotient bit per stage, giving
// the band level from numerator and whole-dB span. Depends on sbm_pkg.
module sbm_div (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  sbm_pkg::div_tok_t in_tok,
  output sbm_pkg::lvl_tok_t out_tok
);
  import sbm_pkg::*;

  typedef struct packed {
    logic              vld;
    logic [BAND_W-1:0] band;
    logic [NUM_W-1:0]  rem;
    logic [DEN_W-1:0]  den;
    logic [LVL_W-1:0]  quo;
  } div_st_t;

  div_st_t st_src [LVL_W];
  div_st_t st_r   [LVL_W];

  assign st_src[0] = '{vld: in_tok.vld, band: in_tok.band, rem: in_tok.num,
                       den: in_tok.den, quo: '0};

  for (genvar s = 0; s < LVL_W; s++) begin : g_stage
    localparam int QBIT = LVL_W - 1 - s;
    logic [NUM_W-1:0] sub_d;
    div_st_t          st_nxt;

    if (s > 0) begin : g_link
      assign st_src[s] = st_r[s-1];
    end

    assign sub_d = NUM_W'(st_src[s].den) << QBIT;

    always_comb begin
      st_nxt = st_src[s];
      if (st_src[s].rem >= sub_d) begin
        st_nxt.rem       = st_src[s].rem - sub_d;
        st_nxt.quo[QBIT] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        st_r[s].vld <= 1'b0;
      end else if (en) begin
        st_r[s] <= st_nxt;
      end
    end
  end

  assign out_tok = '{vld: st_r[LVL_W-1].vld, band: st_r[LVL_W-1].band,
                     level: st_r[LVL_W-1].quo};

endmodule

// ===== hw/rtl/sbm_mem.sv =====
// sbm_mem: per-band bar, peak and hold memory with read-modify-write stage,
// entry valid bits for reset and last-write forwarding. Depends on sbm_pkg.
module sbm_mem #(
  parameter int MAX_BANDS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  sbm_pkg::cfg_t      cfg,
  input  sbm_pkg::lvl_tok_t  in_tok,
  output logic               res_vld,
  output sbm_pkg::out_word_t res_data
);
  import sbm_pkg::*;

  localparam int DEPTH = (MAX_BANDS < (1 << BAND_W)) ? MAX_BANDS : (1 << BAND_W);
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef struct packed {
    logic [LVL_W-1:0]  bar;
    logic [LVL_W-1:0]  peak;
    logic [HOLD_W-1:0] hold;
  } meter_t;

  meter_t           mem [DEPTH];
  logic [DEPTH-1:0] ent_vld_r;
  lvl_tok_t         w_tok_r;
  meter_t           rd_data_r;
  logic             lw_vld_r;
  logic [AW-1:0]    lw_addr_r;
  meter_t           lw_data_r;

  logic [AW-1:0]    w_addr;
  logic [AW-1:0]    rd_addr;
  meter_t           cur;
  meter_t           upd;
  logic [LVL_W-1:0] bar_dec;
  logic [LVL_W-1:0] bar_up;
  logic             wr_en;

  assign w_addr  = w_tok_r.band[AW-1:0];
  // hold the address of the stalled word so its read data stays current
  assign rd_addr = en ? in_tok.band[AW-1:0] : w_addr;
  assign wr_en   = en && w_tok_r.vld;

  always_comb begin
    if (lw_vld_r && (lw_addr_r == w_addr)) begin
      cur = lw_data_r;
    end else if (ent_vld_r[w_addr]) begin
      cur = rd_data_r;
    end else begin
      cur = '0;
    end

    bar_dec = (cur.bar >= cfg.bar_fall_step) ? (cur.bar - cfg.bar_fall_step) : '0;
    bar_up  = (bar_dec < w_tok_r.level) ? w_tok_r.level : bar_dec;
    upd.bar = (bar_up > cfg.max_level) ? cfg.max_level : bar_up;

    if (cur.hold >= cfg.peak_hold_frames) begin
      upd.peak = (cur.peak >= cfg.peak_fall_step) ? (cur.peak - cfg.peak_fall_step) : '0;
      upd.hold = cur.hold;
    end else begin
      upd.peak = cur.peak;
      upd.hold = cur.hold + HOLD_W'(1);
    end
    if (upd.peak < w_tok_r.level) begin
      upd.peak = w_tok_r.level;
      upd.hold = '0;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
    if (wr_en) begin
      mem[w_addr] <= upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_vld_r   <= '0;
      lw_vld_r    <= 1'b0;
      w_tok_r.vld <= 1'b0;
    end else begin
      if (en) begin
        w_tok_r <= in_tok;
      end
      if (wr_en) begin
        ent_vld_r[w_addr] <= 1'b1;
        lw_vld_r          <= 1'b1;
        lw_addr_r         <= w_addr;
        lw_data_r         <= upd;
      end
    end
  end

  assign res_vld  = w_tok_r.vld;
  assign res_data = '{out_band: w_tok_r.band, bar_level: upd.bar, peak_level: upd.peak};

endmodule

// ===== hw/rtl/spectrum_band_meter_top.sv =====
// spectrum_band_meter_top: band maximum tracking, level pipeline, meter
// memory and output skid. Depends on sbm_pkg, sbm_level, sbm_div, sbm_mem.
//
//   port group  dir  handshake            word
//   in_         in   in_valid/in_ready    sbm_pkg::in_word_t
//   out_        out  out_valid/out_ready  sbm_pkg::out_word_t
//   cfg_        in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One input word per cycle sustained while the skid is empty; out_valid rises once a
// last-of-band word with an in-range band is accepted and has passed the input register,
// five level stages, 12-stage divider, meter memory read-modify-write stage and output register.
// Reset (synchronous) clears the running maximum, all band entries through
// per-entry valid bits, and restores register defaults; no clearing pass.
// An output stall fills a one-word skid; in_ready drops only while it is full.
module spectrum_band_meter_top #(
  parameter int MAX_BANDS = 64
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  sbm_pkg::in_word_t                     in_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output sbm_pkg::out_word_t                    out_data,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [sbm_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [sbm_pkg::CFG_DATA_W-1:0]        cfg_data
);
  import sbm_pkg::*;

  cfg_t             cfg_r;
  logic [MAG_W-1:0] running_max_r;
  logic [MAG_W-1:0] running_max_nxt;
  mag_tok_t         p0_r;
  logic             out_valid_r;
  out_word_t        out_data_r;
  logic             skid_vld_r;
  out_word_t        skid_data_r;

  logic             en;
  logic             in_acc;
  logic             in_range;
  logic [BIN_W-1:0] raw;
  logic [BIN_W-1:0] neg;
  logic [MAG_W-1:0] mag;
  logic [MAG_W-1:0] band_max;
  logic             take;
  logic             produce;

  div_tok_t         div_tok;
  lvl_tok_t         lvl_tok;
  logic             res_vld;
  out_word_t        res_data;

  assign en        = !skid_vld_r;
  assign in_ready  = en;
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  assign raw      = in_data.bin_value;
  assign neg      = ~raw + BIN_W'(1);
  // most negative bin saturates to full scale minus one
  assign mag      = raw[BIN_W-1] ? (neg[BIN_W-1] ? '1 : neg[MAG_W-1:0]) : raw[MAG_W-1:0];
  assign band_max = (running_max_r > mag) ? running_max_r : mag;
  assign in_range = (int'(in_data.band_index) < MAX_BANDS);

  always_comb begin
    running_max_nxt = running_max_r;
    if (in_acc) begin
      running_max_nxt = in_data.band_last ? '0 : band_max;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_level        <= RST_MAX_LEVEL;
      cfg_r.min_db           <= RST_MIN_DB;
      cfg_r.bar_fall_step    <= RST_BAR_FALL_STEP;
      cfg_r.peak_hold_frames <= RST_PEAK_HOLD_FRAMES;
      cfg_r.peak_fall_step   <= RST_PEAK_FALL_STEP;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MAX_LEVEL:        cfg_r.max_level        <= cfg_data;
        CFG_MIN_DB:           cfg_r.min_db           <= cfg_data[DB_W-1:0];
        CFG_BAR_FALL_STEP:    cfg_r.bar_fall_step    <= cfg_data;
        CFG_PEAK_HOLD_FRAMES: cfg_r.peak_hold_frames <= cfg_data[HOLD_W-1:0];
        CFG_PEAK_FALL_STEP:   cfg_r.peak_fall_step   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_max_r <= '0;
      p0_r.vld      <= 1'b0;
    end else begin
      running_max_r <= running_max_nxt;
      if (en) begin
        p0_r.vld  <= in_acc && in_data.band_last && in_range;
        p0_r.band <= in_data.band_index;
        p0_r.mag  <= band_max;
      end
    end
  end

  sbm_level u_level (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .cfg     (cfg_r),
    .in_tok  (p0_r),
    .out_tok (div_tok)
  );

  sbm_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_tok  (div_tok),
    .out_tok (lvl_tok)
  );

  sbm_mem #(
    .MAX_BANDS (MAX_BANDS)
  ) u_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .cfg      (cfg_r),
    .in_tok   (lvl_tok),
    .res_vld  (res_vld),
    .res_data (res_data)
  );

  assign take    = out_valid_r && out_ready;
  assign produce = en && res_vld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_vld_r  <= 1'b0;
    end else if (skid_vld_r) begin
      if (take) begin
        out_data_r <= skid_data_r;
        skid_vld_r <= 1'b0;
      end
    end else if (produce) begin
      if (!out_valid_r || take) begin
        out_valid_r <= 1'b1;
        out_data_r  <= res_data;
      end else begin
        skid_vld_r  <= 1'b1;
        skid_data_r <= res_data;
      end
    end else if (take) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_valid_r)
    else $error("skid word held without an output word");

  a_skid_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_vld_r) |-> $past(out_valid_r && !out_ready))
    else $error("skid filled while the output was free");

  a_max_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.band_last) |=> (running_max_r == '0))
    else $error("running maximum not cleared after band end");

endmodule
